// ----- rtl/vsce_pkg.sv -----
// Package: shared types, opcodes and mode-word constants for the stack command encoder.
`default_nettype none

package vsce_pkg;

  // Command codes
  localparam logic [3:0] OP_READ8     = 4'd0;
  localparam logic [3:0] OP_READ16    = 4'd1;
  localparam logic [3:0] OP_READ32    = 4'd2;
  localparam logic [3:0] OP_WRITE8    = 4'd3;
  localparam logic [3:0] OP_WRITE16   = 4'd4;
  localparam logic [3:0] OP_WRITE32   = 4'd5;
  localparam logic [3:0] OP_BLK_READ  = 4'd6;
  localparam logic [3:0] OP_FIFO_READ = 4'd7;
  localparam logic [3:0] OP_REG_READ  = 4'd8;
  localparam logic [3:0] OP_REG_WRITE = 4'd9;
  localparam logic [3:0] OP_DELAY     = 4'd10;
  localparam logic [3:0] OP_MARKER    = 4'd11;
  localparam logic [3:0] OP_CNT_READ8 = 4'd12;
  localparam logic [3:0] OP_CNT_READ16 = 4'd13;
  localparam logic [3:0] OP_CNT_READ32 = 4'd14;

  // Mode word bits
  localparam logic [31:0] M_NW    = 32'h0000_0100;
  localparam logic [31:0] M_NA    = 32'h0000_0400;
  localparam logic [31:0] M_SELF  = 32'h0000_1000;
  localparam logic [31:0] M_MARK  = 32'h0000_2000;
  localparam logic [31:0] M_DELAY = 32'h0000_8000;
  localparam logic [31:0] M_ND    = 32'h0004_0000;

  // MBLT address modifiers
  localparam logic [5:0] AM_MBLT_A32 = 6'h08;
  localparam logic [5:0] AM_MBLT_A24 = 6'h0c;

  localparam int unsigned MAX_WORDS = 3;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [31:0] bus_address;
    logic [5:0]  address_modifier;
    logic [31:0] write_value;
    logic [31:0] transfer_count;
    logic [31:0] count_mask;
  } cmd_t;

  typedef struct packed {
    logic [31:0] stack_word;
    logic        last_word;
  } stk_t;

  // Encoded word set for one command; word[0] goes out first
  typedef struct packed {
    logic [MAX_WORDS-1:0][31:0] word;
    logic [1:0]                 count;
  } word_set_t;

endpackage

`default_nettype wire

// ----- rtl/vsce_encoder.sv -----
// Encoder: request register and the combinational stack word encoding.
`default_nettype none

module vsce_encoder (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_stall,
  input  wire vsce_pkg::cmd_t    cmd,
  output logic                   set_valid,
  output vsce_pkg::word_set_t    set,
  input  wire logic              set_take
);
  import vsce_pkg::*;

  logic  req_valid;
  cmd_t  req;

  logic [31:0] am;
  logic [31:0] a16;
  logic [31:0] a32;
  logic [31:0] strobe;
  logic [31:0] byte_dup;
  logic        mblt;
  logic        cnt_hi;
  logic        cnt_256;
  logic [7:0]  bits;
  logic        ext;
  logic [31:0] blk_mode;

  assign cmd_stall = req_valid && !set_take;
  assign set_valid = req_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!cmd_stall) begin
      req_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      req <= cmd;
    end
  end

  always_comb begin
    am       = {26'd0, req.address_modifier};
    a16      = {req.bus_address[31:1], 1'b1};
    a32      = {req.bus_address[31:2], 2'b00};
    strobe   = req.bus_address[0] ? 32'h40 : 32'h80;
    byte_dup = {16'd0, req.write_value[7:0], req.write_value[7:0]};

    // block count: MBLT allows 256 (encoded as 0); other modes cap at 254
    mblt    = (req.address_modifier == AM_MBLT_A32) ||
              (req.address_modifier == AM_MBLT_A24);
    cnt_hi  = |req.transfer_count[31:8];
    cnt_256 = (req.transfer_count == 32'd256);
    if (mblt) begin
      if (cnt_256) begin
        bits = 8'h00;
      end else if (cnt_hi) begin
        bits = 8'hff;
      end else begin
        bits = req.transfer_count[7:0];
      end
    end else if (cnt_hi || (req.transfer_count[7:0] > 8'd254)) begin
      bits = 8'hff;
    end else begin
      bits = req.transfer_count[7:0];
    end
    ext      = (bits == 8'hff);
    blk_mode = M_NW | am | {bits, 24'd0} |
               ((req.opcode == OP_FIFO_READ) ? M_NA : 32'd0);

    set.word  = '0;
    set.count = 2'd0;
    unique case (req.opcode)
      OP_READ8: begin
        set.word[0] = M_NW | am | strobe;
        set.word[1] = a16;
        set.count   = 2'd2;
      end
      OP_READ16: begin
        set.word[0] = M_NW | am;
        set.word[1] = a16;
        set.count   = 2'd2;
      end
      OP_READ32: begin
        set.word[0] = M_NW | am;
        set.word[1] = a32;
        set.count   = 2'd2;
      end
      OP_WRITE8: begin
        set.word[0] = am | strobe;
        set.word[1] = a16;
        set.word[2] = byte_dup;
        set.count   = 2'd3;
      end
      OP_WRITE16: begin
        set.word[0] = am;
        set.word[1] = a16;
        set.word[2] = {16'd0, req.write_value[15:0]};
        set.count   = 2'd3;
      end
      OP_WRITE32: begin
        set.word[0] = am;
        set.word[1] = a32;
        set.word[2] = req.write_value;
        set.count   = 2'd3;
      end
      OP_BLK_READ, OP_FIFO_READ: begin
        set.word[0] = blk_mode;
        if (ext) begin
          set.word[1] = req.transfer_count;
          set.word[2] = req.bus_address;
          set.count   = 2'd3;
        end else begin
          set.word[1] = req.bus_address;
          set.count   = 2'd2;
        end
      end
      OP_REG_READ: begin
        set.word[0] = M_NW | M_SELF;
        set.word[1] = req.bus_address;
        set.count   = 2'd2;
      end
      OP_REG_WRITE: begin
        set.word[0] = M_SELF;
        set.word[1] = req.bus_address;
        set.word[2] = req.write_value;
        set.count   = 2'd3;
      end
      OP_DELAY: begin
        set.word[0] = M_DELAY | {24'd0, req.write_value[7:0]};
        set.count   = 2'd1;
      end
      OP_MARKER: begin
        set.word[0] = M_MARK;
        set.word[1] = {16'd0, req.write_value[15:0]};
        set.count   = 2'd2;
      end
      OP_CNT_READ8: begin
        set.word[0] = M_ND | M_NW | am | strobe;
        set.word[1] = req.count_mask;
        set.word[2] = a16;
        set.count   = 2'd3;
      end
      OP_CNT_READ16: begin
        set.word[0] = M_ND | M_NW | am;
        set.word[1] = req.count_mask;
        set.word[2] = a16;
        set.count   = 2'd3;
      end
      OP_CNT_READ32: begin
        set.word[0] = M_ND | M_NW | am;
        set.word[1] = req.count_mask;
        set.word[2] = a32;
        set.count   = 2'd3;
      end
      default: begin
        set.count = 2'd0;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_empty_only_unused: assert property (@(posedge clk) disable iff (rst)
    req_valid |-> ((set.count == 2'd0) == (req.opcode == 4'hf)))
    else $error("empty word set for a defined opcode");

  a_ext_three_words: assert property (@(posedge clk) disable iff (rst)
    (req_valid && ext && (req.opcode == OP_BLK_READ || req.opcode == OP_FIFO_READ))
      |-> (set.count == 2'd3))
    else $error("extended count word missing");

  a_held_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !set_take) |=> (req_valid && $stable(req)))
    else $error("request register changed before it was taken");
`endif

endmodule

`default_nettype wire

// ----- rtl/vsce_serializer.sv -----
// Serialiser: spills a word set via an output register, one word a cycle unless stalled.
`default_nettype none

module vsce_serializer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                set_valid,
  input  wire vsce_pkg::word_set_t set,
  output logic                     set_take,
  output logic                     stk_valid,
  input  wire logic                stk_stall,
  output vsce_pkg::stk_t           stk
);
  import vsce_pkg::*;

  logic [1:0][31:0] rem;
  logic [1:0]       rem_cnt;
  logic             out_free;
  logic             load;

  assign out_free = !stk_valid || !stk_stall;
  assign load     = set_valid && out_free && (rem_cnt == 2'd0);
  // an empty set is simply dropped
  assign set_take = set_valid && ((set.count == 2'd0) || load);

  always_ff @(posedge clk) begin
    if (rst) begin
      stk_valid <= 1'b0;
      rem_cnt   <= 2'd0;
    end else if (out_free) begin
      if (rem_cnt != 2'd0) begin
        stk_valid      <= 1'b1;
        stk.stack_word <= rem[0];
        stk.last_word  <= (rem_cnt == 2'd1);
        rem[0]         <= rem[1];
        rem_cnt        <= rem_cnt - 2'd1;
      end else if (load && (set.count != 2'd0)) begin
        stk_valid      <= 1'b1;
        stk.stack_word <= set.word[0];
        stk.last_word  <= (set.count == 2'd1);
        rem[0]         <= set.word[1];
        rem[1]         <= set.word[2];
        rem_cnt        <= set.count - 2'd1;
      end else begin
        stk_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    rem_cnt != 2'd3)
    else $error("more than two words pending");

  a_rem_not_last: assert property (@(posedge clk) disable iff (rst)
    (rem_cnt != 2'd0) |-> (stk_valid && !stk.last_word))
    else $error("words pending behind a last word");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (stk_valid && !stk_stall && !stk.last_word) |=> stk_valid)
    else $error("gap inside one command's words");
`endif

endmodule

`default_nettype wire

// ----- rtl/vme_stack_command_encoder.sv -----
// Top level: bus command to controller stack word encoder.
`default_nettype none

//  channel | direction | payload         | handshake
//  cmd     | in        | vsce_pkg::cmd_t | cmd_valid / cmd_stall
//  stk     | out       | vsce_pkg::stk_t | stk_valid / stk_stall
//
//  A request is registered, encoded in one pass into one to three stack
//  words and sent one word a cycle while stk_stall is low; the next
//  request waits in the request register, so no gap between commands.
//  The first word passes the request register, then the output register,
//  to stk; opcode 15 is accepted and produces no words.
//  Reset (rst, synchronous) empties the request and output registers;
//  stk_stall holds the output word, cmd_stall rises while a request waits.

module vme_stack_command_encoder (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire vsce_pkg::cmd_t cmd,
  output logic                stk_valid,
  input  wire logic           stk_stall,
  output vsce_pkg::stk_t      stk
);
  import vsce_pkg::*;

  logic      set_valid;
  logic      set_take;
  word_set_t set;

  vsce_encoder u_encoder (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .set_valid (set_valid),
    .set       (set),
    .set_take  (set_take)
  );

  vsce_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .set_valid (set_valid),
    .set       (set),
    .set_take  (set_take),
    .stk_valid (stk_valid),
    .stk_stall (stk_stall),
    .stk       (stk)
  );

endmodule

`default_nettype wire
